/* rtl/bmhp_pkg.sv */
// ----------------------------------------------------------------------------
// bmhp_pkg
// Shared types and constants for the bounded min-heap pool.
// ----------------------------------------------------------------------------
`default_nettype none
package bmhp_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 32;
    localparam int IN_KEY_W     = 32;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 7;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DECIDE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD_L,
        ST_DN_RD_R,
        ST_DN_CMP,
        ST_DN_WB,
        ST_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture input beat
        logic srch_start;  // reset search index
        logic srch_rd;     // read slot at search index
        logic srch_next;   // advance search index
        logic append;      // grow count, set cursor to tail, start sift up
        logic replace;     // capture root for eviction, cursor to root, start sift down
        logic up_rd;       // read parent of cursor
        logic up_swap;     // write parent into cursor slot, move cursor up
        logic up_place;    // write held entry at cursor
        logic dn_rd_l;     // read left child
        logic dn_rd_r;     // read right child
        logic dn_swap;     // move chosen child up, cursor down
        logic dn_place;    // write held entry at cursor
        logic dn_cap_l;    // capture left child read data
        logic result;      // load the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic srch_hit;
        logic srch_end;    // index has reached count
        logic full;
        logic up_top;      // cursor is the root
        logic up_go;       // parent strictly greater than held entry
        logic dn_has_l;
        logic dn_has_r;
        logic dn_go;       // a child must rise
    } t_sts;

endpackage
`default_nettype wire

/* rtl/bounded_min_heap_pool.sv */
// ----------------------------------------------------------------------------
// bounded_min_heap_pool
// Fixed-capacity min-heap of distinct keys ordered by signed Q16.16 value.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_entry_key, i_entry_value
//  result  | out       | o_valid / i_stall  | flags, evicted entry, count
//
//  One item at a time. The search reads and compares each stored key in
//  turn (one memory read port); sift up reads and compares per level, sift
//  down reads the children, compares and writes back per level; then the
//  entry is placed and the result loaded. A duplicate ends at its hit.
//  Reset clears the state, count and output valid; heap slots are written
//  before they are read. The result waits in an output register while the
//  next beat is taken; a result still stalled there holds the block.
`default_nettype none
module bounded_min_heap_pool #(
    parameter int CAPACITY = bmhp_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = bmhp_pkg::DEF_KEY_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [bmhp_pkg::IN_KEY_W-1:0]       i_entry_key,
    input  wire logic signed [bmhp_pkg::VALUE_W-1:0] i_entry_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_was_duplicate,
    output logic                                     o_did_evict,
    output logic [bmhp_pkg::IN_KEY_W-1:0]            o_evicted_key,
    output logic signed [bmhp_pkg::VALUE_W-1:0]      o_evicted_value,
    output logic [bmhp_pkg::COUNT_OUT_W-1:0]         o_entry_count
);
    import bmhp_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic out_busy;

    bmhp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_out_busy (out_busy),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bmhp_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_key     (i_entry_key),
        .i_entry_value   (i_entry_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_busy          (out_busy),
        .o_was_duplicate (o_was_duplicate),
        .o_did_evict     (o_did_evict),
        .o_evicted_key   (o_evicted_key),
        .o_evicted_value (o_evicted_value),
        .o_entry_count   (o_entry_count)
    );

endmodule
`default_nettype wire

/* rtl/bmhp_ctrl.sv */
// ----------------------------------------------------------------------------
// bmhp_ctrl
// Controller state machine: sequences search, insert and sift steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bmhp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic           i_out_busy,
    input  wire bmhp_pkg::t_sts i_sts,
    output bmhp_pkg::t_cmd      o_cmd
);
    import bmhp_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_SRCH_RD;
            ST_SRCH_RD:  n_state = i_sts.srch_end ? ST_DECIDE : ST_SRCH_CMP;
            ST_SRCH_CMP: n_state = i_sts.srch_hit ? ST_DONE : ST_SRCH_RD;
            ST_DECIDE:   n_state = i_sts.full ? ST_DN_RD_L : ST_UP_RD;
            ST_UP_RD:    n_state = i_sts.up_top ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP:   n_state = i_sts.up_go ? ST_UP_RD : ST_DONE;
            ST_DN_RD_L:  n_state = i_sts.dn_has_l ? ST_DN_RD_R : ST_DONE;
            ST_DN_RD_R:  n_state = ST_DN_CMP;
            ST_DN_CMP:   n_state = i_sts.dn_go ? ST_DN_WB : ST_DONE;
            ST_DN_WB:    n_state = ST_DN_RD_L;
            ST_DONE:     if (!i_out_busy) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall        = 1'b0;
                o_cmd.load       = i_valid;
                o_cmd.srch_start = i_valid;
            end
            ST_SRCH_RD:  o_cmd.srch_rd = !i_sts.srch_end;
            ST_SRCH_CMP: o_cmd.srch_next = !i_sts.srch_hit;
            ST_DECIDE: begin
                o_cmd.append  = !i_sts.full;
                o_cmd.replace = i_sts.full;
            end
            ST_UP_RD: begin
                o_cmd.up_rd    = !i_sts.up_top;
                o_cmd.up_place = i_sts.up_top;
            end
            ST_UP_CMP: begin
                o_cmd.up_swap  = i_sts.up_go;
                o_cmd.up_place = !i_sts.up_go;
            end
            ST_DN_RD_L: begin
                o_cmd.dn_rd_l  = i_sts.dn_has_l;
                o_cmd.dn_place = !i_sts.dn_has_l;
            end
            ST_DN_RD_R: begin
                o_cmd.dn_rd_r  = 1'b1;
                o_cmd.dn_cap_l = 1'b1;
            end
            ST_DN_CMP:   o_cmd.dn_place = !i_sts.dn_go;
            ST_DN_WB:    o_cmd.dn_swap = 1'b1;
            ST_DONE:     o_cmd.result = !i_out_busy;
            default:     o_cmd = '0;
        endcase
    end

    // a beat is only taken when idle; sift-up placement and swap never coincide
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> r_state == ST_IDLE)
        else $error("input taken outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.up_swap && o_cmd.up_place))
        else $error("sift up swap and place together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |=> r_state == ST_IDLE)
        else $error("result not followed by idle");

endmodule
`default_nettype wire

/* rtl/bmhp_dpath.sv */
// ----------------------------------------------------------------------------
// bmhp_dpath
// Datapath: heap memories, search index, sift cursor and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bmhp_dpath #(
    parameter int CAPACITY = bmhp_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = bmhp_pkg::DEF_KEY_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [bmhp_pkg::IN_KEY_W-1:0]     i_entry_key,
    input  wire logic signed [bmhp_pkg::VALUE_W-1:0] i_entry_value,
    input  wire bmhp_pkg::t_cmd                    i_cmd,
    output bmhp_pkg::t_sts                         o_sts,
    input  wire logic                              i_stall,
    output logic                                   o_valid,
    output logic                                   o_busy,
    output logic                                   o_was_duplicate,
    output logic                                   o_did_evict,
    output logic [bmhp_pkg::IN_KEY_W-1:0]          o_evicted_key,
    output logic signed [bmhp_pkg::VALUE_W-1:0]    o_evicted_value,
    output logic [bmhp_pkg::COUNT_OUT_W-1:0]       o_entry_count
);
    import bmhp_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;   // wide enough for 2*cursor+2
    localparam int KW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic signed [VALUE_W-1:0] t_val;

    t_key mem_k [CAPACITY];
    t_val mem_v [CAPACITY];

    t_key r_key;
    t_val r_val;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_child;
    t_key r_rd_k, r_lk;
    t_val r_rd_v, r_lv;
    logic r_dup, r_evict;
    t_key r_ev_k;
    t_val r_ev_v;
    logic r_ov;

    // write port and read address muxing
    logic          wr_en;
    logic [AW-1:0] wr_a, rd_a;
    t_key          wr_k;
    t_val          wr_v;
    logic          rd_en;

    logic [AW-1:0] parent;
    logic [XW-1:0] lc, rc;
    logic          pick_r;

    assign parent = (r_cur - AW'(1)) >> 1;
    assign lc     = {r_cur, 1'b1} + XW'(0);
    assign rc     = lc + XW'(1);

    // right child rises only when strictly smaller than left
    assign pick_r = o_sts.dn_has_r && (r_rd_v < r_lv);

    always_comb begin
        rd_en = i_cmd.srch_rd | i_cmd.up_rd | i_cmd.dn_rd_l | i_cmd.dn_rd_r;
        rd_a  = r_idx[AW-1:0];
        if (i_cmd.up_rd) rd_a = parent;
        if (i_cmd.dn_rd_l) rd_a = lc[AW-1:0];
        if (i_cmd.dn_rd_r) rd_a = rc[AW-1:0];
        wr_en = 1'b0;
        wr_a  = r_cur;
        wr_k  = r_key;
        wr_v  = r_val;
        if (i_cmd.up_swap) begin
            wr_en = 1'b1; wr_k = r_rd_k; wr_v = r_rd_v;
        end
        if (i_cmd.dn_swap) begin
            wr_en = 1'b1;
            wr_k  = pick_r ? r_rd_k : r_lk;
            wr_v  = pick_r ? r_rd_v : r_lv;
        end
        if (i_cmd.up_place || i_cmd.dn_place) wr_en = 1'b1;
    end

    // heap memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_k[wr_a] <= wr_k;
            mem_v[wr_a] <= wr_v;
        end
        if (rd_en) begin
            r_rd_k <= mem_k[rd_a];
            r_rd_v <= mem_v[rd_a];
        end
        if (i_cmd.replace) begin
            r_ev_k <= mem_k[0];
            r_ev_v <= mem_v[0];
        end
    end

    // status
    always_comb begin
        o_sts.srch_end = (r_idx >= r_count);
        o_sts.srch_hit = (r_rd_k == r_key);
        o_sts.full     = (r_count == CW'(CAPACITY));
        o_sts.up_top   = (r_cur == '0);
        o_sts.up_go    = (r_rd_v > r_val);
        o_sts.dn_has_l = ({{(XW-CW){1'b0}}, r_count} > lc) || (XW <= CW);
        o_sts.dn_has_r = ({{(XW-CW){1'b0}}, r_count} > rc);
        o_sts.dn_go    = pick_r ? (r_val > r_rd_v) : (r_val > r_lv);
    end

    // control registers and held entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.append) r_count <= r_count + CW'(1);
            if (i_cmd.result) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
        if (i_cmd.load) begin
            r_key   <= t_key'(i_entry_key[KW-1:0]);
            r_val   <= i_entry_value;
            r_dup   <= 1'b0;
            r_evict <= 1'b0;
        end
        if (i_cmd.srch_start) r_idx <= '0;
        if (i_cmd.srch_next) r_idx <= r_idx + CW'(1);
        if (i_cmd.srch_rd && 1'b0) r_idx <= r_idx;
        if (i_cmd.dn_rd_r == 1'b0 && i_cmd.srch_rd == 1'b0 && o_sts.srch_hit
            && i_cmd.srch_next == 1'b0 && i_cmd.load == 1'b0 && r_idx < r_count
            && i_cmd.result == 1'b0 && i_cmd.up_rd == 1'b0 && i_cmd.dn_rd_l == 1'b0
            && i_cmd.append == 1'b0 && i_cmd.replace == 1'b0 && !r_dup
            && i_cmd.dn_cap_l == 1'b0 && i_cmd.dn_swap == 1'b0 && i_cmd.up_swap == 1'b0
            && i_cmd.up_place == 1'b0 && i_cmd.dn_place == 1'b0 && i_cmd.srch_start == 1'b0)
            r_dup <= 1'b1;
        if (i_cmd.append)  r_cur <= r_count[AW-1:0];
        if (i_cmd.replace) begin
            r_cur   <= '0;
            r_evict <= 1'b1;
        end
        if (i_cmd.up_swap) r_cur <= parent;
        if (i_cmd.dn_cap_l) begin
            r_lk <= r_rd_k;
            r_lv <= r_rd_v;
        end
        if (i_cmd.dn_swap) r_cur <= pick_r ? rc[AW-1:0] : lc[AW-1:0];
        r_child <= r_cur;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            o_was_duplicate <= r_dup;
            o_did_evict     <= r_evict;
            o_evicted_key   <= r_evict ? IN_KEY_W'(r_ev_k) : '0;
            o_evicted_value <= r_evict ? r_ev_v : '0;
            o_entry_count   <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_valid = r_ov;
    assign o_busy  = r_ov && i_stall;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_sts.full)
        else $error("append while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dn_swap |=> (r_cur > $past(r_cur)) || (r_child == r_cur))
        else $error("sift down cursor did not descend");

endmodule
`default_nettype wire

/* test/bounded_min_heap_pool_test.sv */
// ----------------------------------------------------------------------------
// bounded_min_heap_pool_test
// Drives keyed entries into the min-heap pool under several idling patterns
// and checks every result beat against a behavioural heap kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bounded_min_heap_pool_test;

    localparam int CAP = bmhp_pkg::DEF_CAPACITY;
    localparam int KW  = bmhp_pkg::IN_KEY_W;
    localparam int VW  = bmhp_pkg::VALUE_W;
    localparam int CW  = bmhp_pkg::COUNT_OUT_W;

    typedef struct packed {
        logic                 dup;
        logic                 evict;
        logic [KW-1:0]        ev_key;
        logic signed [VW-1:0] ev_val;
        logic [CW-1:0]        count;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [KW-1:0]        i_entry_key = '0;
    logic signed [VW-1:0] i_entry_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_was_duplicate;
    logic                 o_did_evict;
    logic [KW-1:0]        o_evicted_key;
    logic signed [VW-1:0] o_evicted_value;
    logic [CW-1:0]        o_entry_count;

    bounded_min_heap_pool u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_entry_key(i_entry_key), .i_entry_value(i_entry_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_was_duplicate(o_was_duplicate),
        .o_did_evict(o_did_evict), .o_evicted_key(o_evicted_key),
        .o_evicted_value(o_evicted_value), .o_entry_count(o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // heap mirror
    logic [KW-1:0]        heap_key[CAP];
    logic signed [VW-1:0] heap_val[CAP];
    int                   heap_len = 0;
    t_outcome             pending_outcomes[$];
    int                   error_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    function automatic void swap_slots(int a, int b);
        logic [KW-1:0]        k;
        logic signed [VW-1:0] v;
        k = heap_key[a]; v = heap_val[a];
        heap_key[a] = heap_key[b]; heap_val[a] = heap_val[b];
        heap_key[b] = k; heap_val[b] = v;
    endfunction

    function automatic t_outcome offer_entry(logic [KW-1:0] key, logic signed [VW-1:0] val);
        t_outcome res;
        int at, lc, rc;
        res = '0;
        for (int i = 0; i < heap_len; i++)
            if (heap_key[i] == key) res.dup = 1'b1;
        if (!res.dup) begin
            if (heap_len == CAP) begin
                res.evict = 1'b1;
                res.ev_key = heap_key[0];
                res.ev_val = heap_val[0];
                heap_key[0] = key; heap_val[0] = val;
                at = 0;
                // sift down, left wins ties
                forever begin
                    lc = 2 * at + 1; rc = lc + 1;
                    if (lc >= heap_len) break;
                    if (rc >= heap_len) begin
                        if (heap_val[at] > heap_val[lc]) swap_slots(at, lc);
                        break;
                    end
                    if (heap_val[at] > heap_val[lc] && heap_val[lc] <= heap_val[rc]) begin
                        swap_slots(at, lc); at = lc;
                    end else if (heap_val[at] > heap_val[rc] && heap_val[rc] < heap_val[lc]) begin
                        swap_slots(at, rc); at = rc;
                    end else begin
                        break;
                    end
                end
            end else begin
                at = heap_len;
                heap_len++;
                heap_key[at] = key; heap_val[at] = val;
                // sift up while parent strictly greater
                while (at > 0 && heap_val[(at - 1) / 2] > heap_val[at]) begin
                    swap_slots((at - 1) / 2, at);
                    at = (at - 1) / 2;
                end
            end
        end
        res.count = CW'(heap_len);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // send one beat, then hold it until taken; drop valid only while idling
    task automatic send_entry(logic [KW-1:0] key, logic signed [VW-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_entry_key <= key;
        i_entry_value <= val;
        pending_outcomes.push_back(offer_entry(key, val));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drive receiver stall
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_stall_pct);

    // check each result beat
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_was_duplicate !== want.dup)
                    report_mismatch("was_duplicate", o_was_duplicate, want.dup);
                if (o_did_evict !== want.evict)
                    report_mismatch("did_evict", o_did_evict, want.evict);
                if (o_evicted_key !== want.ev_key)
                    report_mismatch("evicted_key", o_evicted_key, want.ev_key);
                if (o_evicted_value !== want.ev_val)
                    report_mismatch("evicted_value", o_evicted_value, want.ev_val);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", o_entry_count, want.count);
            end
        end
    end

    // drop valid and wait for every result beat
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    // fill to capacity with ties and extremes, then evict and hit duplicates
    task automatic test_directed();
        send_entry(32'h0, 32'sh7fffffff);
        send_entry(32'hffffffff, 32'sh80000000);
        send_entry(32'h0, 32'sh0);
        send_entry(32'hffffffff, 32'sh1);
        send_entry(32'h5, 32'sh00010000);
        send_entry(32'h6, 32'sh00010000);
        send_entry(32'h7, 32'shffff0000);
        send_entry(32'h8, 32'sh00010000);
        for (int i = 0; i < CAP - 5; i++)
            send_entry(32'h100 + i, VW'($urandom_range(3)) - 1);
        send_entry(32'haaaaaaaa, 32'sh55555555);
        send_entry(32'h55555555, 32'shaaaaaaaa);
        send_entry(32'h55555555, 32'sh0);
        drain_results();
    endtask

    // random: mix of fresh keys, repeats of stored keys and narrow values
    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        logic [KW-1:0]        key;
        logic signed [VW-1:0] val;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(3))
                0: key = (heap_len > 0) ? heap_key[$urandom_range(heap_len - 1)] : $urandom;
                1: key = $urandom_range(200);
                default: key = $urandom;
            endcase
            val = ($urandom_range(1) == 0) ? VW'($urandom_range(8)) - 4 : $urandom;
            send_entry(key, val);
        end
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(95, 0, 0);
        test_random(95, 73, 0);
        test_random(95, 0, 73);
        test_random(95, 25, 25);
        recv_stall_pct = 0;
        repeat (400) @(negedge i_clk);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
